>>> hw/rtl/dlf_pkg.sv
// ----------------------------------------------------------------------------
// dlf_pkg: shared types and constants for the day length factor core
// Item structs, fixed-point widths, CORDIC arc table, pipeline depths and
// the per-month declination tangent table built at elaboration.
// ----------------------------------------------------------------------------
package dlf_pkg;

    localparam int MONTHS  = 12;
    localparam int MONTH_W = 4;
    localparam int LAT_W   = 16;
    localparam int DECL_W  = 14;
    localparam int HOUR_W  = 13;
    localparam int FAC_W   = 16;
    localparam int ANG_W   = 24;   // angle in 1/65536 degree, within +-90 degrees
    localparam int TAN_W   = 26;   // tangent in Q16, saturates at +-2^24

    localparam int ITER       = 18;  // CORDIC steps
    localparam int TQ_BITS    = 24;  // tangent quotient bits
    localparam int SQRT_STEPS = 17;  // integer square root digits
    localparam int RATIO_BITS = 16;  // factor quotient bits

    localparam int TAN_LAT   = ITER + TQ_BITS + 2;
    localparam int DH_LAT    = 3 + SQRT_STEPS + 1 + ITER + 4;
    localparam int RATIO_LAT = RATIO_BITS + 2;
    localparam int PIPE_LAT  = 1 + TAN_LAT + DH_LAT + RATIO_LAT;

    localparam int CORDIC_GAIN = 652032874;
    localparam int DEG90       = 5898240;
    localparam int DEG180      = 11796480;

    localparam logic [DECL_W-1:0]       MAX_DECL_RESET = 14'd6001;
    localparam logic [DECL_W-1:0]       MAX_DECL_LIMIT = 14'd11520;
    localparam logic signed [LAT_W-1:0] LAT_LIMIT      = 16'sd23040;
    localparam logic signed [TAN_W-1:0] TAN_SAT        = 26'sd16777216;
    localparam logic [HOUR_W-1:0]       FULL_DAY       = 13'd6144;
    localparam logic [FAC_W-1:0]        FACTOR_FLOOR   = 16'd328;
    localparam logic [FAC_W-1:0]        FACTOR_ONE     = 16'd32768;

    localparam int ATAN_STEPS [ITER] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
        7334, 3667, 1833, 917, 458, 229, 115, 57, 29
    };

    typedef struct packed {
        logic signed [LAT_W-1:0] latitude;
        logic [MONTH_W-1:0]      month_index;
    } t_in_item;

    typedef struct packed {
        logic [FAC_W-1:0]  factor;
        logic [HOUR_W-1:0] daylight;
        logic [HOUR_W-1:0] max_day_length;
    } t_out_item;

    typedef struct packed {
        longint c;
        longint s;
    } t_sincos;

    typedef logic [MONTHS-1:0][TAN_W-1:0] t_tan_table;

    // Rotation CORDIC in Q30 on an angle in (-180, 180] degrees.
    function automatic t_sincos sincos_q30(input longint ang);
        longint  x;
        longint  y;
        longint  z;
        longint  dx;
        longint  dy;
        bit      flip;
        int      i;
        t_sincos res;
        x    = CORDIC_GAIN;
        y    = 0;
        z    = ang;
        flip = 1'b0;
        if (z > DEG90) begin
            z    = z - DEG180;
            flip = 1'b1;
        end else if (z < -DEG90) begin
            z    = z + DEG180;
            flip = 1'b1;
        end
        for (i = 0; i < ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEPS[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEPS[i];
            end
        end
        res.c = flip ? -x : x;
        res.s = flip ? -y : y;
        return res;
    endfunction

    // Tangent of the mid-month declination, Q16, truncated toward zero.
    function automatic longint month_tan(input int m);
        longint  ang;
        longint  c;
        longint  s;
        longint  c2;
        longint  s2;
        longint  sum;
        longint  decl;
        longint  mag;
        longint  rem;
        longint  dd;
        longint  q;
        t_sincos sc;
        int      k;
        ang = ((longint'(m) * 30 + 15) * 23592960 + 182) / 365;
        if (ang > DEG180) begin
            ang = ang - 2 * longint'(DEG180);
        end
        sc   = sincos_q30(ang);
        c    = sc.c;
        s    = sc.s;
        c2   = (c * c - s * s) >>> 30;
        s2   = (2 * s * c) >>> 30;
        sum  = -longint'(1501646) * c + longint'(263811) * s
             - longint'(25376) * c2 + longint'(3408) * s2;
        decl = 25977 + ((sum + (longint'(1) << 29)) >>> 30);
        sc   = sincos_q30(decl);
        c    = sc.c;
        s    = sc.s;
        mag  = (s < 0) ? -s : s;
        if (c <= 0 || mag * 65536 >= longint'(16777216) * c) begin
            if (s > 0) return longint'(16777216);
            if (s < 0) return -longint'(16777216);
            return 0;
        end
        rem = mag * 65536;
        q   = 0;
        for (k = TQ_BITS - 1; k >= 0; k--) begin
            dd = c <<< k;
            if (rem >= dd) begin
                rem = rem - dd;
                q   = q | (longint'(1) << k);
            end
        end
        return (s < 0) ? -q : q;
    endfunction

    function automatic t_tan_table build_month_tan();
        t_tan_table tbl;
        longint     t;
        int         m;
        for (m = 0; m < MONTHS; m++) begin
            t      = month_tan(m);
            tbl[m] = t[TAN_W-1:0];
        end
        return tbl;
    endfunction

    localparam t_tan_table MONTH_TAN = build_month_tan();

endpackage

>>> hw/rtl/dlf_tan.sv
// ----------------------------------------------------------------------------
// dlf_tan: pipelined tangent
// Rotation CORDIC for sine and cosine, then a one-bit-per-stage divider
// for sin/cos in Q16 with saturation near the poles.
// ----------------------------------------------------------------------------
module dlf_tan (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [dlf_pkg::ANG_W-1:0] i_angle,
    output logic signed [dlf_pkg::TAN_W-1:0] o_tan
);
    localparam int NI = dlf_pkg::ITER;
    localparam int CW = 32;
    localparam int ZW = 26;
    localparam int QB = dlf_pkg::TQ_BITS;
    localparam int RW = CW + 16;
    localparam int DW = CW - 1 + QB;

    logic signed [CW-1:0] r_x [NI];
    logic signed [CW-1:0] r_y [NI];
    logic signed [ZW-1:0] r_z [NI];

    // Input angle is within +-90 degrees, so no quadrant fold is needed.
    for (genvar i = 0; i < NI; i++) begin : g_rot
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        if (i == 0) begin : g_first
            assign x_in = CW'(dlf_pkg::CORDIC_GAIN);
            assign y_in = '0;
            assign z_in = ZW'(i_angle);
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (z_in >= 0) begin
                    r_x[i] <= x_in - (y_in >>> i);
                    r_y[i] <= y_in + (x_in >>> i);
                    r_z[i] <= z_in - ZW'(dlf_pkg::ATAN_STEPS[i]);
                end else begin
                    r_x[i] <= x_in + (y_in >>> i);
                    r_y[i] <= y_in - (x_in >>> i);
                    r_z[i] <= z_in + ZW'(dlf_pkg::ATAN_STEPS[i]);
                end
            end
        end
    end

    logic signed [CW-1:0] cos_v;
    logic signed [CW-1:0] sin_v;
    logic [CW-1:0]        sin_mag;
    logic                 sat;

    assign cos_v   = r_x[NI-1];
    assign sin_v   = r_y[NI-1];
    assign sin_mag = sin_v[CW-1] ? CW'(-sin_v) : CW'(sin_v);
    // |sin| * 2^16 >= 2^24 * cos  <=>  |sin| >= cos * 2^8
    assign sat     = (cos_v <= 0) || ({8'b0, sin_mag} >= {cos_v, 8'b0});

    logic [RW-1:0]   r_rem [QB+1];
    logic [CW-2:0]   r_div [QB+1];
    logic [QB-1:0]   r_q   [QB+1];
    logic            r_sat [QB+1];
    logic            r_pos [QB+1];
    logic            r_neg [QB+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {sin_mag, 16'b0};
            r_div[0] <= cos_v[CW-2:0];
            r_q[0]   <= '0;
            r_sat[0] <= sat;
            r_pos[0] <= !sin_v[CW-1] && (sin_v != 0);
            r_neg[0] <= sin_v[CW-1];
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        logic [DW-1:0] rem_ext;
        logic [DW-1:0] shifted;
        logic          take;
        assign rem_ext = DW'(r_rem[j]);
        assign shifted = DW'(r_div[j]) << K;
        assign take    = rem_ext >= shifted;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= take ? RW'(rem_ext - shifted) : r_rem[j];
                r_q[j+1]   <= r_q[j] | (take ? (QB'(1) << K) : QB'(0));
                r_div[j+1] <= r_div[j];
                r_sat[j+1] <= r_sat[j];
                r_pos[j+1] <= r_pos[j];
                r_neg[j+1] <= r_neg[j];
            end
        end
    end

    logic signed [dlf_pkg::TAN_W-1:0] q_s;
    assign q_s = signed'(dlf_pkg::TAN_W'(r_q[QB]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sat[QB]) begin
                if (r_pos[QB]) begin
                    o_tan <= dlf_pkg::TAN_SAT;
                end else if (r_neg[QB]) begin
                    o_tan <= -dlf_pkg::TAN_SAT;
                end else begin
                    o_tan <= '0;
                end
            end else begin
                o_tan <= r_neg[QB] ? -q_s : q_s;
            end
        end
    end

endmodule

>>> hw/rtl/dlf_day_hours.sv
// ----------------------------------------------------------------------------
// dlf_day_hours: pipelined day length
// x = -tan(lat)*tan(decl), sqrt(1-x^2) by digit stages, vectoring CORDIC
// for acos(x), then degrees to 1/256 hour with a reciprocal multiply.
// ----------------------------------------------------------------------------
module dlf_day_hours (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [dlf_pkg::TAN_W-1:0]  i_tlat,
    input  logic signed [dlf_pkg::TAN_W-1:0]  i_tdecl,
    output logic [dlf_pkg::HOUR_W-1:0]        o_hours
);
    localparam int TW    = dlf_pkg::TAN_W;
    localparam int PW    = 2 * (TW - 1);
    localparam int XW    = 18;
    localparam int SQ    = dlf_pkg::SQRT_STEPS;
    localparam int SW    = 34;
    localparam int VW    = 34;
    localparam int ZW    = 26;
    localparam int NI    = dlf_pkg::ITER;
    localparam int RECIP = 1073742;   // ceil(2^27 / 125)

    // flag bit 1: polar night, bit 0: polar day
    logic [1:0] r_fl2;
    logic [PW-1:0] r_prod;
    logic          r_neg;

    logic [TW-2:0] a_lat;
    logic [TW-2:0] a_dec;
    logic signed [TW-1:0] n_lat;
    logic signed [TW-1:0] n_dec;
    assign n_lat = -i_tlat;
    assign n_dec = -i_tdecl;
    assign a_lat = i_tlat[TW-1]  ? n_lat[TW-2:0] : i_tlat[TW-2:0];
    assign a_dec = i_tdecl[TW-1] ? n_dec[TW-2:0] : i_tdecl[TW-2:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(a_lat) * PW'(a_dec);
            r_neg  <= i_tlat[TW-1] ^ i_tdecl[TW-1];
        end
    end

    logic [PW-17:0]       mag;
    logic                 big;
    logic signed [XW-1:0] r_xq;
    assign mag = r_prod[PW-1:16];
    assign big = mag > (PW-16)'(65536);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fl2 <= {r_neg && big, !r_neg && big};
            r_xq  <= r_neg ? signed'(mag[XW-1:0]) : -signed'(mag[XW-1:0]);
        end
    end

    logic [16:0] axq;
    logic [SW-1:0] sq;
    logic signed [XW-1:0] n_xq;
    assign n_xq = -r_xq;
    assign axq  = r_xq[XW-1] ? n_xq[16:0] : r_xq[16:0];
    assign sq   = SW'(axq) * SW'(axq);

    logic [SW-1:0]        r_sv  [SQ+1];
    logic [SW-1:0]        r_sr  [SQ+1];
    logic signed [XW-1:0] r_sxq [SQ+1];
    logic [1:0]           r_sfl [SQ+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sv[0]  <= (SW'(1) << 32) - sq;
            r_sr[0]  <= '0;
            r_sxq[0] <= r_xq;
            r_sfl[0] <= r_fl2;
        end
    end

    for (genvar i = 0; i < SQ; i++) begin : g_sqrt
        localparam int SH = 2 * (SQ - 1 - i);
        logic [SW-1:0] bitv;
        logic [SW-1:0] t;
        logic          take;
        assign bitv = SW'(1) << SH;
        assign t    = r_sr[i] + bitv;
        assign take = r_sv[i] >= t;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sv[i+1]  <= take ? r_sv[i] - t : r_sv[i];
                r_sr[i+1]  <= take ? (r_sr[i] >> 1) + bitv : r_sr[i] >> 1;
                r_sxq[i+1] <= r_sxq[i];
                r_sfl[i+1] <= r_sfl[i];
            end
        end
    end

    logic signed [VW-1:0] sx;
    logic signed [VW-1:0] sy;
    assign sx = VW'(r_sxq[SQ]) <<< 14;
    assign sy = signed'(r_sr[SQ] << 14);

    logic signed [VW-1:0] r_vx [NI+1];
    logic signed [VW-1:0] r_vy [NI+1];
    logic signed [ZW-1:0] r_vz [NI+1];
    logic [1:0]           r_vfl [NI+1];

    // Fold negative x into the right half plane with a quarter turn.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (sx < 0) begin
                r_vx[0] <= sy;
                r_vy[0] <= -sx;
                r_vz[0] <= ZW'(dlf_pkg::DEG90);
            end else begin
                r_vx[0] <= sx;
                r_vy[0] <= sy;
                r_vz[0] <= '0;
            end
            r_vfl[0] <= r_sfl[SQ];
        end
    end

    for (genvar i = 0; i < NI; i++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_vy[i] > 0) begin
                    r_vx[i+1] <= r_vx[i] + (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] - (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] + ZW'(dlf_pkg::ATAN_STEPS[i]);
                end else begin
                    r_vx[i+1] <= r_vx[i] - (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] + (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] - ZW'(dlf_pkg::ATAN_STEPS[i]);
                end
                r_vfl[i+1] <= r_vfl[i];
            end
        end
    end

    logic signed [ZW-1:0] vz;
    logic [23:0]          zc;
    assign vz = r_vz[NI];

    always_comb begin
        if (vz < 0) begin
            zc = '0;
        end else if (vz > ZW'(dlf_pkg::DEG180)) begin
            zc = 24'(dlf_pkg::DEG180);
        end else begin
            zc = vz[23:0];
        end
    end

    logic [31:0] r_p;
    logic [20:0] r_n;
    logic [41:0] r_m;
    logic [1:0]  r_hfl1;
    logic [1:0]  r_hfl2;
    logic [1:0]  r_hfl3;

    // hours = round(z * 133 / 256000): add half, drop 2^11, then divide by 125
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= 32'(zc) * 32'd133;
            r_hfl1 <= r_vfl[NI];
            r_n    <= 21'((33'(r_p) + 33'd128000) >> 11);
            r_hfl2 <= r_hfl1;
            r_m    <= 42'(r_n) * 42'(RECIP);
            r_hfl3 <= r_hfl2;
            if (r_hfl3[1]) begin
                o_hours <= '0;
            end else if (r_hfl3[0]) begin
                o_hours <= dlf_pkg::FULL_DAY;
            end else begin
                o_hours <= r_m[27 +: dlf_pkg::HOUR_W];
            end
        end
    end

endmodule

>>> hw/rtl/dlf_ratio.sv
// ----------------------------------------------------------------------------
// dlf_ratio: day length factor
// Rounded Q1.15 quotient of the two day lengths, one bit per stage, with
// the floor and full-scale special cases applied at the end.
// ----------------------------------------------------------------------------
module dlf_ratio (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [dlf_pkg::HOUR_W-1:0]  i_dyl,
    input  logic [dlf_pkg::HOUR_W-1:0]  i_dmax,
    output dlf_pkg::t_out_item          o_item
);
    localparam int HW = dlf_pkg::HOUR_W;
    localparam int QB = dlf_pkg::RATIO_BITS;
    localparam int RW = HW + 16;

    logic [RW-1:0] r_rem  [QB+1];
    logic [HW-1:0] r_dyl  [QB+1];
    logic [HW-1:0] r_dmax [QB+1];
    logic [QB-1:0] r_q    [QB+1];
    logic          r_zero [QB+1];
    logic          r_gt   [QB+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= (RW'(i_dyl) << 15) + RW'(i_dmax >> 1);
            r_dyl[0]  <= i_dyl;
            r_dmax[0] <= i_dmax;
            r_q[0]    <= '0;
            r_zero[0] <= (i_dyl == '0) || (i_dmax == '0);
            r_gt[0]   <= i_dyl > i_dmax;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        logic [RW-1:0] shifted;
        logic          take;
        assign shifted = RW'(r_dmax[j]) << K;
        assign take    = r_rem[j] >= shifted;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= take ? r_rem[j] - shifted : r_rem[j];
                r_q[j+1]    <= r_q[j] | (take ? (QB'(1) << K) : QB'(0));
                r_dyl[j+1]  <= r_dyl[j];
                r_dmax[j+1] <= r_dmax[j];
                r_zero[j+1] <= r_zero[j];
                r_gt[j+1]   <= r_gt[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[QB]) begin
                o_item.factor <= dlf_pkg::FACTOR_FLOOR;
            end else if (r_gt[QB]) begin
                o_item.factor <= dlf_pkg::FACTOR_ONE;
            end else begin
                o_item.factor <= r_q[QB];
            end
            o_item.daylight       <= r_dyl[QB];
            o_item.max_day_length <= r_dmax[QB];
        end
    end

endmodule

>>> hw/rtl/day_length_factor_core.sv
// ----------------------------------------------------------------------------
// day_length_factor_core: day length factor for one site and one month
// Throughput: one item per cycle; the whole pipeline advances on one enable
// and holds when the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits and loads the
// maximum declination register with 23.44 degrees.
// ----------------------------------------------------------------------------
module day_length_factor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dlf_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dlf_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [dlf_pkg::DECL_W-1:0]    i_cfg_data
);
    localparam int LAT = dlf_pkg::PIPE_LAT;
    localparam int TL  = dlf_pkg::TAN_LAT;

    logic                         en;
    logic [LAT-1:0]               r_vld;
    logic [dlf_pkg::DECL_W-1:0]   r_max_decl;

    assign en          = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_max_decl <= dlf_pkg::MAX_DECL_RESET;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], i_in_valid};
            end
            if (i_cfg_we) begin
                r_max_decl <= i_cfg_data;
            end
        end
    end

    // Input stage: clamp fields, form angles, look up the month tangent.
    logic signed [dlf_pkg::LAT_W-1:0]  lat_c;
    logic [dlf_pkg::MONTH_W-1:0]       mon_c;
    logic [dlf_pkg::DECL_W-1:0]        md_c;
    logic signed [dlf_pkg::ANG_W-1:0]  md_ang;

    always_comb begin
        if (i_in_data.latitude > dlf_pkg::LAT_LIMIT) begin
            lat_c = dlf_pkg::LAT_LIMIT;
        end else if (i_in_data.latitude < -dlf_pkg::LAT_LIMIT) begin
            lat_c = -dlf_pkg::LAT_LIMIT;
        end else begin
            lat_c = i_in_data.latitude;
        end
        if (i_in_data.month_index >= dlf_pkg::MONTH_W'(dlf_pkg::MONTHS)) begin
            mon_c = dlf_pkg::MONTH_W'(dlf_pkg::MONTHS - 1);
        end else begin
            mon_c = i_in_data.month_index;
        end
        md_c   = (r_max_decl > dlf_pkg::MAX_DECL_LIMIT) ? dlf_pkg::MAX_DECL_LIMIT
                                                        : r_max_decl;
        md_ang = signed'({2'b0, md_c, 8'b0});
    end

    logic signed [dlf_pkg::ANG_W-1:0] r_lat_ang;
    logic signed [dlf_pkg::ANG_W-1:0] r_mdecl_ang;
    logic signed [dlf_pkg::TAN_W-1:0] r_mtan;
    logic signed [dlf_pkg::TAN_W-1:0] r_mtan_dly [TL];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat_ang   <= {lat_c, 8'b0};
            // zero latitude takes the southern sign
            r_mdecl_ang <= (lat_c <= 0) ? -md_ang : md_ang;
            r_mtan      <= signed'(dlf_pkg::MONTH_TAN[mon_c]);
            r_mtan_dly[0] <= r_mtan;
            for (int k = 1; k < TL; k++) begin
                r_mtan_dly[k] <= r_mtan_dly[k-1];
            end
        end
    end

    logic signed [dlf_pkg::TAN_W-1:0] tan_lat;
    logic signed [dlf_pkg::TAN_W-1:0] tan_max;

    dlf_tan u_tan_lat (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_lat_ang),
        .o_tan   (tan_lat)
    );

    dlf_tan u_tan_max (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_mdecl_ang),
        .o_tan   (tan_max)
    );

    logic [dlf_pkg::HOUR_W-1:0] dyl;
    logic [dlf_pkg::HOUR_W-1:0] dmax;

    dlf_day_hours u_hours_month (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_tlat  (tan_lat),
        .i_tdecl (r_mtan_dly[TL-1]),
        .o_hours (dyl)
    );

    dlf_day_hours u_hours_max (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_tlat  (tan_lat),
        .i_tdecl (tan_max),
        .o_hours (dmax)
    );

    dlf_ratio u_ratio (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_dyl  (dyl),
        .i_dmax (dmax),
        .o_item (o_out_data)
    );

endmodule
